[sv/elpf_pkg.sv]
// Shared types, constants and the sequencer program of the escaped log packet framer.
// Used by elpf_seq and escaped_log_packet_framer_unit; depends on nothing else.
package elpf_pkg;

  // Framing bytes and limits.
  localparam logic [7:0] START_BYTE     = 8'hFE;
  localparam logic [7:0] TYPE_TIMESTAMP = 8'hFF;
  localparam logic [7:0] ESC_A          = 8'hFC;
  localparam logic [7:0] ESC_B          = 8'hFD;
  localparam logic [7:0] OFFSET_RESET   = 8'd125;
  localparam int unsigned MAX_ARGS      = 6;
  localparam int unsigned STEP_W        = 4;
  localparam int unsigned CNT_W         = 3;

  // Input item: one packet request.
  typedef struct packed {
    logic        kind;
    logic [2:0]  arg_count;
    logic [15:0] msg_id;
    logic [15:0] arg0;
    logic [15:0] arg1;
    logic [15:0] arg2;
    logic [15:0] arg3;
    logic [15:0] arg4;
    logic [15:0] arg5;
    logic [31:0] tick_count;
    logic [7:0]  timer_count;
  } in_item_t;

  // Result item: one byte of the framed stream.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // Byte source selected by a control word.
  typedef enum logic [3:0] {
    SRC_START,
    SRC_TS_TYPE,
    SRC_COUNT,
    SRC_TICK3,
    SRC_TICK2,
    SRC_TICK1,
    SRC_TICK0,
    SRC_ID_HI,
    SRC_ID_LO,
    SRC_MICRO,
    SRC_ARG_HI,
    SRC_ARG_LO
  } src_t;

  // Sequencing operation of a control word.
  typedef enum logic [2:0] {
    OP_NEXT,
    OP_JMP_PRINT,
    OP_END,
    OP_END_IF_NOARGS,
    OP_LOOP
  } op_t;

  typedef struct packed {
    src_t              src;
    logic              esc;
    op_t               op;
    logic [STEP_W-1:0] target;
  } uword_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    src_t src;
    logic esc;
    logic ends;
  } ctrl_t;

  // Program steps.
  localparam logic [STEP_W-1:0] STEP_TS_TYPE = 4'd1;
  localparam logic [STEP_W-1:0] STEP_COUNT   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_ARG_HI  = 4'd11;

  // Microprogram: timestamp branch in steps 1..5, print branch in steps 6..12.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{src: SRC_START, esc: 1'b0, op: OP_END, target: STEP_TS_TYPE};
    unique case (step)
      4'd0:  w = '{src: SRC_START,   esc: 1'b0, op: OP_JMP_PRINT,     target: STEP_COUNT};
      4'd1:  w = '{src: SRC_TS_TYPE, esc: 1'b0, op: OP_NEXT,          target: STEP_TS_TYPE};
      4'd2:  w = '{src: SRC_TICK3,   esc: 1'b1, op: OP_NEXT,          target: STEP_TS_TYPE};
      4'd3:  w = '{src: SRC_TICK2,   esc: 1'b1, op: OP_NEXT,          target: STEP_TS_TYPE};
      4'd4:  w = '{src: SRC_TICK1,   esc: 1'b1, op: OP_NEXT,          target: STEP_TS_TYPE};
      4'd5:  w = '{src: SRC_TICK0,   esc: 1'b1, op: OP_END,           target: STEP_TS_TYPE};
      4'd6:  w = '{src: SRC_COUNT,   esc: 1'b0, op: OP_NEXT,          target: STEP_TS_TYPE};
      4'd7:  w = '{src: SRC_ID_HI,   esc: 1'b1, op: OP_NEXT,          target: STEP_TS_TYPE};
      4'd8:  w = '{src: SRC_ID_LO,   esc: 1'b1, op: OP_NEXT,          target: STEP_TS_TYPE};
      4'd9:  w = '{src: SRC_TICK0,   esc: 1'b1, op: OP_NEXT,          target: STEP_TS_TYPE};
      4'd10: w = '{src: SRC_MICRO,   esc: 1'b1, op: OP_END_IF_NOARGS, target: STEP_TS_TYPE};
      4'd11: w = '{src: SRC_ARG_HI,  esc: 1'b1, op: OP_NEXT,          target: STEP_TS_TYPE};
      4'd12: w = '{src: SRC_ARG_LO,  esc: 1'b1, op: OP_LOOP,          target: STEP_ARG_HI};
      default: w = '{src: SRC_START, esc: 1'b0, op: OP_END,           target: STEP_TS_TYPE};
    endcase
    return w;
  endfunction

endpackage

[sv/elpf_seq.sv]
// Microcoded sequencer of the packet framer: step counter, argument counter
// and the program table from elpf_pkg.
module elpf_seq
  import elpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             advance,
  input  logic             kind,
  input  logic [CNT_W-1:0] cnt,
  output ctrl_t            ctrl,
  output logic [CNT_W-1:0] arg_idx
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [CNT_W-1:0]  arg_idx_next;
  uword_t            uw;
  logic [CNT_W:0]    idx_inc;
  logic              more_args;

  // Decode the current control word and choose the following step.
  always_comb begin
    uw           = ucode(step);
    idx_inc      = {1'b0, arg_idx} + {{CNT_W{1'b0}}, 1'b1};
    more_args    = idx_inc < {1'b0, cnt};
    step_next    = step + {{(STEP_W-1){1'b0}}, 1'b1};
    arg_idx_next = arg_idx;
    ctrl.src     = uw.src;
    ctrl.esc     = uw.esc;
    ctrl.ends    = 1'b0;
    unique case (uw.op)
      OP_NEXT: begin
      end
      OP_JMP_PRINT: begin
        if (kind) begin
          step_next = uw.target;
        end
      end
      OP_END: begin
        ctrl.ends = 1'b1;
      end
      OP_END_IF_NOARGS: begin
        ctrl.ends = (cnt == '0);
      end
      OP_LOOP: begin
        ctrl.ends = !more_args;
        if (more_args) begin
          step_next    = uw.target;
          arg_idx_next = idx_inc[CNT_W-1:0];
        end
      end
      default: begin
        ctrl.ends = 1'b1;
      end
    endcase
  end

  // Step and argument counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= '0;
      arg_idx <= '0;
    end else if (start) begin
      step    <= '0;
      arg_idx <= '0;
    end else if (advance) begin
      step    <= step_next;
      arg_idx <= arg_idx_next;
    end
  end

endmodule

[sv/escaped_log_packet_framer_unit.sv]
// The item is registered when accepted; the first byte of its packet then enters the output register.
// Throughput: one output byte per cycle without stall; a packet is 6 to 34 bytes
// (2 raw bytes plus one or two per escaped byte), set by the one-byte output register.
// A new item is taken once the previous packet's last byte sits in the output register,
// so the packets of two items never overlap in the output.
// Reset (synchronous rst) clears the sequencer and output valid and sets the offset to 125.
module escaped_log_packet_framer_unit
  import elpf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_wen,
  input  logic [7:0] cfg_wdata
);

  logic [7:0]       offset;
  in_item_t         item;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             pend_valid;
  logic [7:0]       pend_byte;
  logic             pend_last;
  logic             accept;
  logic             load_ok;
  logic             advance;
  ctrl_t            ctrl;
  logic [CNT_W-1:0] arg_idx;
  logic [15:0]      arg_word;
  logic [7:0]       micro;
  logic [7:0]       sel_byte;
  logic             needs_esc;
  logic [7:0]       first_byte;
  logic [7:0]       second_byte;

  assign in_stall = run || pend_valid;
  assign accept   = in_valid && !in_stall;
  assign load_ok  = !out_valid || !out_stall;
  assign advance  = run && !pend_valid && load_ok;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= OFFSET_RESET;
    end else if (cfg_wen) begin
      offset <= cfg_wdata;
    end
  end

  // Capture the item and the saturated argument count.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
      cnt  <= (in_data.arg_count > CNT_W'(MAX_ARGS)) ? CNT_W'(MAX_ARGS)
                                                      : in_data.arg_count;
    end
  end

  elpf_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .advance (advance),
    .kind    (item.kind),
    .cnt     (cnt),
    .ctrl    (ctrl),
    .arg_idx (arg_idx)
  );

  // Argument selected by the argument counter.
  always_comb begin
    unique case (arg_idx)
      3'd0:    arg_word = item.arg0;
      3'd1:    arg_word = item.arg1;
      3'd2:    arg_word = item.arg2;
      3'd3:    arg_word = item.arg3;
      3'd4:    arg_word = item.arg4;
      3'd5:    arg_word = item.arg5;
      default: arg_word = item.arg5;
    endcase
  end

  assign micro = item.timer_count + offset;

  // Byte source multiplexer.
  always_comb begin
    unique case (ctrl.src)
      SRC_START:   sel_byte = START_BYTE;
      SRC_TS_TYPE: sel_byte = TYPE_TIMESTAMP;
      SRC_COUNT:   sel_byte = {{(8-CNT_W){1'b0}}, cnt};
      SRC_TICK3:   sel_byte = item.tick_count[31:24];
      SRC_TICK2:   sel_byte = item.tick_count[23:16];
      SRC_TICK1:   sel_byte = item.tick_count[15:8];
      SRC_TICK0:   sel_byte = item.tick_count[7:0];
      SRC_ID_HI:   sel_byte = item.msg_id[15:8];
      SRC_ID_LO:   sel_byte = item.msg_id[7:0];
      SRC_MICRO:   sel_byte = micro;
      SRC_ARG_HI:  sel_byte = arg_word[15:8];
      SRC_ARG_LO:  sel_byte = arg_word[7:0];
      default:     sel_byte = START_BYTE;
    endcase
  end

  // Escape: the special bytes become a two-byte sequence.
  always_comb begin
    needs_esc   = ctrl.esc &&
                  (sel_byte == ESC_A || sel_byte == ESC_B || sel_byte == START_BYTE);
    first_byte  = sel_byte;
    second_byte = ESC_A;
    if (needs_esc) begin
      first_byte  = (sel_byte == START_BYTE) ? ESC_B : ESC_A;
      second_byte = (sel_byte == START_BYTE) ? ESC_A : sel_byte;
    end
  end

  // Sequencer run flag, escape holding byte and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      run        <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        run <= 1'b1;
      end
      if (load_ok) begin
        if (pend_valid) begin
          out_valid         <= 1'b1;
          out_data.out_byte <= pend_byte;
          out_data.last     <= pend_last;
          pend_valid        <= 1'b0;
        end else if (run) begin
          out_valid         <= 1'b1;
          out_data.out_byte <= first_byte;
          out_data.last     <= ctrl.ends && !needs_esc;
          pend_valid        <= needs_esc;
          pend_byte         <= second_byte;
          pend_last         <= ctrl.ends;
          run               <= !ctrl.ends;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTH
  // A held escape byte always sits behind a valid output byte.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid) else $error("escape byte held without output byte");

  // An accepted item starts the sequencer.
  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> run) else $error("sequencer not started after item");

  // The final held byte of a packet means the sequencer has finished.
  a_last_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && pend_last) |-> !run) else $error("sequencer running past packet end");
`endif

endmodule
